// ===== sv/tcmd_pkg.sv =====
package tcmd_pkg;

  // Luma and alpha weights of the color distance
  localparam logic [14:0] WT_RED   = 15'd2126;
  localparam logic [14:0] WT_GREEN = 15'd7152;
  localparam logic [14:0] WT_BLUE  = 15'd722;
  localparam logic [14:0] WT_ALPHA = 15'd20000;

  // Spread over ten as (x * SPREAD_RECIP) >> SPREAD_SHIFT, exact for x below 2^23
  localparam logic [23:0] SPREAD_RECIP = 24'd6710887;
  localparam int          SPREAD_SHIFT = 26;

  // Component codes within a packed RGBA word
  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;
  localparam logic [1:0] COMP_ALPHA = 2'd3;

  localparam int NUM_W = 33;  // dividend and quotient width
  localparam int DEN_W = 16;  // divisor width

  function automatic logic [7:0] comp_of(input logic [31:0] word, input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      COMP_RED:   r = word[7:0];
      COMP_GREEN: r = word[15:8];
      COMP_BLUE:  r = word[23:16];
      default:    r = word[31:24];
    endcase
    return r;
  endfunction

  function automatic logic [14:0] weight_of(input logic [1:0] sel);
    logic [14:0] r;
    case (sel)
      COMP_RED:   r = WT_RED;
      COMP_GREEN: r = WT_GREEN;
      COMP_BLUE:  r = WT_BLUE;
      default:    r = WT_ALPHA;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/two_color_mix_ordered_dither.sv =====
// Two-color mixing ordered dither with a loadable RGBA palette.
// Input channel (pixel_valid / pixel_stall) takes one item per handshake:
// mode 0 writes red/green/blue/alpha into palette slot entry_slot and gives
// no result; mode 1 dithers a pixel and gives exactly one out_index item on
// the result channel (result_valid / result_stall).
// Configuration is to be written through cfg_write / cfg_index / cfg_data
// only while idle; the block itself does not enforce this. A load leaves
// the block idle, and a transparent pixel goes straight to its result. Any
// other pixel walks every palette entry in use through one shared multiplier
// and one serial divider, and the sequencer waits for each division. A
// candidate with no differing component takes four divisions, a fully mixed
// one nine, and a skipped transparent entry none; the divisions dominate a
// pixel's time.
// pixel_stall is high whenever a pixel is in work; a finished result sits in
// the output register while a load or the next pixel is taken, and the block
// waits at the end of a pixel only if the previous result is still stalled.
// Reset (rst, synchronous) sets palette_count 256, no transparent index and
// max_mix 63; the palette contents stay undefined until loaded.
module two_color_mix_ordered_dither
  import tcmd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_stall,
  input  logic       mode,
  input  logic [7:0] entry_slot,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] alpha,
  input  logic [7:0] nearest_index,
  input  logic [7:0] threshold,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_index,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  localparam logic [1:0] REG_PALETTE_COUNT = 2'd0;
  localparam logic [1:0] REG_TRANSPARENT   = 2'd1;
  localparam logic [1:0] REG_MAX_MIX       = 2'd2;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RDN   = 5'd1;
  localparam logic [4:0] S_CAND  = 5'd2;
  localparam logic [4:0] S_RDC   = 5'd3;
  localparam logic [4:0] S_TERM  = 5'd4;
  localparam logic [4:0] S_TMUL  = 5'd5;
  localparam logic [4:0] S_TDIV  = 5'd6;
  localparam logic [4:0] S_TWAIT = 5'd7;
  localparam logic [4:0] S_MDIV  = 5'd8;
  localparam logic [4:0] S_MWAIT = 5'd9;
  localparam logic [4:0] S_XMUL  = 5'd10;
  localparam logic [4:0] S_XDIV  = 5'd11;
  localparam logic [4:0] S_XWAIT = 5'd12;
  localparam logic [4:0] S_XAMUL = 5'd13;
  localparam logic [4:0] S_XACC  = 5'd14;
  localparam logic [4:0] S_DMUL  = 5'd15;
  localparam logic [4:0] S_DACC  = 5'd16;
  localparam logic [4:0] S_DDIV  = 5'd17;
  localparam logic [4:0] S_DWAIT = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;

  // Configuration registers
  logic [8:0]        palette_count;
  logic signed [8:0] transparent_index;
  logic [7:0]        max_mix;

  logic [4:0]  state;
  logic [31:0] p_word, n_word, c_word;
  logic [7:0]  nidx, thr;
  logic [8:0]  cand;
  logic [1:0]  kk;
  logic signed [NUM_W-1:0] prod, mix;
  logic [14:0] divsum;
  logic [7:0]  m_alpha;
  logic [7:0]  m_val;
  logic [23:0] score, best;
  logic [22:0] dnc;
  logic        have;
  logic [7:0]  alt, bestmix, res;

  logic        accept, nidx_oob, slot_ok, tr_on, tr_hit, rgb_ok, counted;
  logic [8:0]  cnt;
  logic [7:0]  scale;
  logic [1:0]  comp;
  logic [7:0]  pk, nk, ck;
  logic signed [9:0] dk, pn, pm;
  logic [7:0]  abs_pm, abs_nc;
  logic [14:0] wk;
  logic signed [24:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [48:0] mul_full;
  logic        div_start, div_busy, div_done;
  logic signed [NUM_W-1:0] div_num, div_quot;
  logic signed [DEN_W-1:0] div_den;
  logic signed [NUM_W-1:0] mix_clamped;
  logic [23:0] cand_score;
  logic [AW-1:0] raddr;
  logic [31:0] rdata;

  assign accept      = pixel_valid && !pixel_stall;
  assign pixel_stall = (state != S_IDLE);
  assign nidx_oob    = {1'b0, nidx} >= 9'(PALETTE_DEPTH);
  assign slot_ok     = {1'b0, entry_slot} < 9'(PALETTE_DEPTH);
  assign cnt         = (palette_count > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : palette_count;
  assign scale       = (max_mix == 8'd0) ? 8'd1 : max_mix;
  assign tr_on       = !transparent_index[8];
  assign tr_hit      = tr_on && (cand == transparent_index[8:0]);

  // Component walk: alpha first, then red, green, blue
  assign comp    = (kk == 2'd0) ? COMP_ALPHA : kk - 2'd1;
  assign pk      = comp_of(p_word, comp);
  assign nk      = comp_of(n_word, comp);
  assign ck      = comp_of(c_word, comp);
  assign wk      = weight_of(comp);
  assign dk      = $signed({2'b00, ck}) - $signed({2'b00, nk});
  assign pn      = $signed({2'b00, pk}) - $signed({2'b00, nk});
  assign pm      = $signed({2'b00, pk}) - $signed({2'b00, m_val});
  assign abs_pm  = pm[9] ? 8'(-pm) : pm[7:0];
  assign abs_nc  = dk[9] ? 8'(-dk) : dk[7:0];
  assign rgb_ok  = (p_word[31:24] != 8'd0) && (n_word[31:24] != 8'd0) &&
                   (c_word[31:24] != 8'd0);
  assign counted = (comp == COMP_ALPHA) || rgb_ok;

  // Shared multiplier operand select
  always_comb begin
    case (state)
      S_TERM: begin
        mul_a = $signed({10'd0, wk});
        mul_b = $signed({16'd0, scale});
      end
      S_TMUL: begin
        mul_a = prod[24:0];
        mul_b = 24'(pn);
      end
      S_XMUL: begin
        mul_a = 25'(dk);
        mul_b = 24'(mix[9:0]);
      end
      S_XAMUL: begin
        mul_a = $signed({17'd0, abs_pm});
        mul_b = $signed({9'd0, wk});
      end
      S_DMUL: begin
        mul_a = $signed({17'd0, abs_nc});
        mul_b = $signed({9'd0, wk});
      end
      S_DDIV: begin
        mul_a = $signed({2'd0, dnc});
        mul_b = $signed(SPREAD_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = prod;
    div_den   = DEN_W'(dk);
    case (state)
      S_TDIV: begin
        div_start = 1'b1;
      end
      S_MDIV: begin
        div_start = (mix != '0);
        div_num   = mix;
        div_den   = $signed({1'b0, divsum});
      end
      S_XDIV: begin
        div_start = 1'b1;
        div_den   = $signed({8'd0, scale});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (div_quot < 0) begin
      mix_clamped = '0;
    end else if (div_quot > $signed({25'd0, scale})) begin
      mix_clamped = $signed({25'd0, scale});
    end else begin
      mix_clamped = div_quot;
    end
  end

  assign cand_score = score + {1'b0, dnc};
  assign raddr      = (state == S_CAND) ? cand[AW-1:0] : nearest_index[AW-1:0];

  tcmd_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_palette (
    .clk   (clk),
    .we    (accept && !mode && slot_ok),
    .waddr (entry_slot[AW-1:0]),
    .wdata ({alpha, blue, green, red}),
    .raddr (raddr),
    .rdata (rdata)
  );

  tcmd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count     <= 9'd256;
      transparent_index <= -9'sd1;
      max_mix           <= 8'd63;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PALETTE_COUNT: palette_count     <= cfg_data;
        REG_TRANSPARENT:   transparent_index <= $signed(cfg_data);
        REG_MAX_MIX:       max_mix           <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // Present a finished result, or drop one the receiver has taken
      if (state == S_FIN && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && mode) begin
            p_word <= {alpha, blue, green, red};
            nidx   <= nearest_index;
            thr    <= threshold;
            if (tr_on && alpha == 8'd0) begin
              res   <= transparent_index[7:0];
              state <= S_FIN;
            end else begin
              state <= S_RDN;
            end
          end
        end
        S_RDN: begin
          n_word <= nidx_oob ? 32'd0 : rdata;
          cand   <= '0;
          have   <= 1'b0;
          state  <= S_CAND;
        end
        S_CAND: begin
          if (cand >= cnt) begin
            res   <= (have && thr < bestmix) ? alt : nidx;
            state <= S_FIN;
          end else if (tr_hit) begin
            cand <= cand + 1'b1;
          end else begin
            state <= S_RDC;
          end
        end
        S_RDC: begin
          c_word <= rdata;
          kk     <= '0;
          mix    <= '0;
          divsum <= '0;
          state  <= S_TERM;
        end
        // Weighted mix terms, one division per differing component that counts
        S_TERM: begin
          if (counted && dk != 10'sd0) begin
            prod   <= mul_full[NUM_W-1:0];
            divsum <= divsum + wk;
            state  <= S_TMUL;
          end else if (kk == 2'd3) begin
            state <= S_MDIV;
          end else begin
            kk <= kk + 1'b1;
          end
        end
        S_TMUL: begin
          prod  <= mul_full[NUM_W-1:0];
          state <= S_TDIV;
        end
        S_TDIV: begin
          state <= S_TWAIT;
        end
        S_TWAIT: begin
          if (div_done) begin
            mix <= mix + div_quot;
            if (kk == 2'd3) begin
              state <= S_MDIV;
            end else begin
              kk    <= kk + 1'b1;
              state <= S_TERM;
            end
          end
        end
        // Normalize and clamp the mix factor
        S_MDIV: begin
          kk    <= '0;
          score <= '0;
          state <= (mix != '0) ? S_MWAIT : S_XMUL;
        end
        S_MWAIT: begin
          if (div_done) begin
            mix   <= mix_clamped;
            state <= S_XMUL;
          end
        end
        // Interpolated color and its distance to the pixel
        S_XMUL: begin
          prod  <= mul_full[NUM_W-1:0];
          state <= S_XDIV;
        end
        S_XDIV: begin
          state <= S_XWAIT;
        end
        S_XWAIT: begin
          if (div_done) begin
            m_val <= nk + div_quot[7:0];
            if (comp == COMP_ALPHA) begin
              m_alpha <= nk + div_quot[7:0];
            end
            state <= S_XAMUL;
          end
        end
        S_XAMUL: begin
          prod  <= mul_full[NUM_W-1:0];
          state <= S_XACC;
        end
        S_XACC: begin
          if (comp == COMP_ALPHA || (p_word[31:24] != 8'd0 && m_alpha != 8'd0)) begin
            score <= score + prod[23:0];
          end
          if (kk == 2'd3) begin
            kk    <= '0;
            dnc   <= '0;
            state <= S_DMUL;
          end else begin
            kk    <= kk + 1'b1;
            state <= S_XMUL;
          end
        end
        // Spread between nearest and candidate
        S_DMUL: begin
          prod  <= mul_full[NUM_W-1:0];
          state <= S_DACC;
        end
        S_DACC: begin
          if (comp == COMP_ALPHA || (n_word[31:24] != 8'd0 && c_word[31:24] != 8'd0)) begin
            dnc <= dnc + prod[22:0];
          end
          if (kk == 2'd3) begin
            state <= S_DDIV;
          end else begin
            kk    <= kk + 1'b1;
            state <= S_DMUL;
          end
        end
        // Scale the spread by one tenth through the reciprocal
        S_DDIV: begin
          dnc   <= mul_full[SPREAD_SHIFT +: 23];
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (!have || cand_score < best) begin
            have    <= 1'b1;
            best    <= cand_score;
            bestmix <= mix[7:0];
            alt     <= cand[7:0];
          end
          cand  <= cand + 1'b1;
          state <= S_CAND;
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            out_index <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The divider is never restarted while it runs
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  // The clamped mix factor stays within the scale
  a_mix_range: assert property (@(posedge clk) disable iff (rst)
    state == S_XMUL |-> (mix >= 0 && mix <= $signed({25'd0, scale})))
    else $error("mix factor out of range");

  // The transparent entry is never scored
  a_skip_tr: assert property (@(posedge clk) disable iff (rst)
    state == S_RDC |-> !tr_hit) else $error("transparent entry scored");

  // A score is only taken for an entry in use
  a_cand_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DWAIT |-> cand < cnt) else $error("candidate beyond count");

endmodule

// ===== sv/tcmd_ram.sv =====
module tcmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tcmd_div.sv =====
module tcmd_div
  import tcmd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    busy,
  output logic                    done,
  output logic signed [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] count;
  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] dabs;
  logic             neg;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // Restoring step on magnitudes, one quotient bit a cycle
  always_comb begin
    shifted = {rem[DEN_W-1:0], quo[NUM_W-1]};
    fits    = shifted >= {1'b0, dabs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
        rem   <= '0;
        quo   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dabs  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        neg   <= num[NUM_W-1] ^ den[DEN_W-1];
      end else if (busy) begin
        rem   <= fits ? shifted - {1'b0, dabs} : shifted;
        quo   <= {quo[NUM_W-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Truncate toward zero: apply the sign to the magnitude quotient
  assign quot = neg ? -$signed(quo) : $signed(quo);

endmodule

// ===== test/tcmd_tb_pkg.sv =====
`timescale 1ns / 100ps
package tcmd_tb_pkg;

  // Item kinds on the input channel
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PALETTE_COUNT = 2'd0;
  localparam logic [1:0] CFG_TRANSPARENT   = 2'd1;
  localparam logic [1:0] CFG_MAX_MIX       = 2'd2;

  localparam logic [8:0] NO_TRANSPARENT = 9'h1FF;

endpackage

// ===== test/tcmd_scoreboard.sv =====
`timescale 1ns / 100ps
module tcmd_scoreboard
  import tcmd_pkg::*;
  import tcmd_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  input  logic       pixel_stall,
  input  logic       mode,
  input  logic [7:0] entry_slot,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] alpha,
  input  logic [7:0] nearest_index,
  input  logic [7:0] threshold,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [7:0] out_index,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         errors,
  output int         pending
);

  logic [31:0]       palette_mirror [256];
  logic [8:0]        count_reg;
  logic signed [8:0] transp_reg;
  logic [7:0]        max_mix_reg;
  logic [7:0]        index_queue [$];

  function automatic longint weight(input int k);
    return longint'(weight_of(k[1:0]));
  endfunction

  // Luma weighted RGB distance plus alpha distance
  function automatic longint color_dist(input logic [31:0] x, input logic [31:0] y);
    longint s;
    longint d;
    s = 0;
    if (x[31:24] != 0 && y[31:24] != 0) begin
      for (int k = 0; k < 3; k++) begin
        d = longint'(x[8*k +: 8]) - longint'(y[8*k +: 8]);
        if (d < 0) d = -d;
        s += d * weight(k);
      end
    end
    d = longint'(x[31:24]) - longint'(y[31:24]);
    if (d < 0) d = -d;
    s += d * weight(3);
    return s;
  endfunction

  // Pick between the nearest entry and its best mixing partner
  function automatic logic [7:0] dither_index(input logic [31:0] px, input logic [7:0] nidx,
                                              input logic [7:0] thr);
    logic [31:0] ne, ce, me;
    longint scale, best, bestmix, mix, dv, score, dk, pk, nk, ck;
    int cnt, alt_i;
    bit have, all_opaque;
    if (transp_reg >= 0 && px[31:24] == 0) return transp_reg[7:0];
    ne = palette_mirror[nidx];
    scale = (max_mix_reg == 0) ? 1 : longint'(max_mix_reg);
    cnt = (count_reg > 256) ? 256 : int'(count_reg);
    have = 0;
    best = 0;
    bestmix = 0;
    alt_i = 0;
    for (int i = 0; i < cnt; i++) begin
      if (transp_reg >= 0 && i == int'(transp_reg)) continue;
      ce = palette_mirror[i];
      all_opaque = px[31:24] != 0 && ne[31:24] != 0 && ce[31:24] != 0;
      mix = 0;
      dv = 0;
      for (int k = 0; k < 4; k++) begin
        pk = longint'(px[8*k +: 8]);
        nk = longint'(ne[8*k +: 8]);
        ck = longint'(ce[8*k +: 8]);
        dk = ck - nk;
        if (k < 3 && !all_opaque) continue;
        if (dk != 0) begin
          mix += weight(k) * scale * (pk - nk) / dk;
          dv += weight(k);
        end
      end
      if (mix != 0) begin
        if (dv != 0) mix = mix / dv;
        if (mix < 0) mix = 0;
        if (mix > scale) mix = scale;
      end
      for (int k = 0; k < 4; k++) begin
        nk = longint'(ne[8*k +: 8]);
        ck = longint'(ce[8*k +: 8]);
        me[8*k +: 8] = 8'(nk + (ck - nk) * mix / scale);
      end
      score = color_dist(px, me) + color_dist(ne, ce) / 10;
      if (!have || score < best) begin
        have = 1;
        best = score;
        bestmix = mix;
        alt_i = i;
      end
    end
    if (have && longint'(thr) < bestmix) return alt_i[7:0];
    return nidx;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  assign pending = index_queue.size();

  initial errors = 0;

  // Track configuration, palette loads, and compare results
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      count_reg <= 9'd256;
      transp_reg <= -9'sd1;
      max_mix_reg <= 8'd63;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PALETTE_COUNT: count_reg <= cfg_data;
          CFG_TRANSPARENT:   transp_reg <= cfg_data;
          CFG_MAX_MIX:       max_mix_reg <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) begin
        if (mode == MODE_LOAD)
          palette_mirror[entry_slot] = {alpha, blue, green, red};
        else
          index_queue.push_back(dither_index({alpha, blue, green, red}, nearest_index,
                                             threshold));
      end
      if (result_valid && !result_stall) begin
        if (index_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected out_index %0d", out_index));
        end else begin
          want = index_queue.pop_front();
          if (out_index !== want)
            report_mismatch($sformatf("out_index %0d, expected %0d", out_index, want));
        end
      end
    end
  end

endmodule

// ===== test/two_color_mix_ordered_dither_tb.sv =====
`timescale 1ns / 100ps
module two_color_mix_ordered_dither_tb;
  import tcmd_pkg::*;
  import tcmd_tb_pkg::*;

  localparam int STALL_LIMIT = 60000;

  logic       clk, rst;
  logic       pixel_valid, pixel_stall;
  logic       mode;
  logic [7:0] entry_slot, red, green, blue, alpha, nearest_index, threshold;
  logic       result_valid, result_stall;
  logic [7:0] out_index;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  int         errors, pending;

  int  send_idle_pct, recv_stall_pct;
  bit  hold_req, holding;
  bit  written [256];
  int  quiet_cycles;
  logic [31:0] shade [256];

  two_color_mix_ordered_dither u_dut (.*);

  tcmd_scoreboard u_scoreboard (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stall, or a long hold-off on request
  initial begin
    holding = 0;
    @(posedge hold_req);
    holding = 1;
    repeat (12000) @(posedge clk);
    holding = 0;
  end

  always @(posedge clk)
    result_stall <= holding || ($urandom_range(99) < recv_stall_pct);

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("two_color_mix_ordered_dither test failed");
      $finish;
    end
  end

  task automatic send(input logic m, input logic [7:0] slot, input logic [31:0] rgba,
                      input logic [7:0] nidx, input logic [7:0] thr);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 0;
      @(posedge clk);
    end
    pixel_valid <= 1;
    mode <= m;
    entry_slot <= slot;
    {alpha, blue, green, red} <= rgba;
    nearest_index <= nidx;
    threshold <= thr;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    if (m == MODE_LOAD) written[slot] = 1;
  endtask

  task automatic load(input logic [7:0] slot, input logic [31:0] rgba);
    shade[slot] = rgba;
    send(MODE_LOAD, slot, rgba, 8'd0, 8'd0);
  endtask

  task automatic dither(input logic [31:0] rgba, input logic [7:0] nidx,
                        input logic [7:0] thr);
    send(MODE_PIXEL, 8'd0, rgba, nidx, thr);
  endtask

  // Drain results, then write one register
  task automatic set_reg(input logic [1:0] idx, input logic [8:0] value);
    pixel_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 0;
  endtask

  function automatic int written_prefix();
    int k;
    k = 0;
    while (k < 256 && written[k]) k++;
    return k;
  endfunction

  function automatic logic [7:0] pick_written();
    logic [7:0] s;
    do s = 8'($urandom_range(255)); while (!written[s]);
    return s;
  endfunction

  // Random entry, mostly opaque
  function automatic logic [31:0] rand_color();
    logic [7:0] a;
    case ($urandom_range(5))
      0: a = 8'd0;
      1: a = 8'($urandom);
      default: a = 8'd255;
    endcase
    return {a, 8'($urandom), 8'($urandom), 8'($urandom)};
  endfunction

  // Pixel near a blend of two loaded entries, now and then a random color
  function automatic logic [31:0] rand_pixel(input logic [7:0] nidx);
    logic [31:0] a, b, r;
    int t;
    if ($urandom_range(9) == 0) return rand_color();
    a = shade[nidx];
    b = shade[pick_written()];
    t = $urandom_range(16);
    for (int k = 0; k < 4; k++)
      r[8*k +: 8] = 8'((int'(a[8*k +: 8]) * (16 - t) + int'(b[8*k +: 8]) * t) / 16);
    if ($urandom_range(7) == 0) r[31:24] = 8'd0;
    return r;
  endfunction

  task automatic random_phase(input int n_items, input int top_slot);
    int pre, cnt;
    logic [7:0] nidx;
    pre = written_prefix();
    cnt = (pre < 12) ? pre : $urandom_range(12, 1);
    set_reg(CFG_PALETTE_COUNT, 9'(cnt));
    case ($urandom_range(2))
      0: set_reg(CFG_TRANSPARENT, NO_TRANSPARENT);
      1: set_reg(CFG_TRANSPARENT, 9'($urandom_range(cnt - 1)));
      default: set_reg(CFG_TRANSPARENT, 9'($urandom_range(255)));
    endcase
    case ($urandom_range(3))
      0: set_reg(CFG_MAX_MIX, 9'd1);
      1: set_reg(CFG_MAX_MIX, 9'd255);
      default: set_reg(CFG_MAX_MIX, 9'($urandom_range(254, 2)));
    endcase
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(3) == 0) begin
        load(8'($urandom_range(top_slot)), rand_color());
      end else begin
        nidx = pick_written();
        dither(rand_pixel(nidx), nidx, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst = 1;
    pixel_valid = 0;
    mode = MODE_LOAD;
    entry_slot = 0;
    red = 0;
    green = 0;
    blue = 0;
    alpha = 0;
    nearest_index = 0;
    threshold = 0;
    cfg_write = 0;
    cfg_index = CFG_PALETTE_COUNT;
    cfg_data = 0;
    result_stall = 0;
    hold_req = 0;
    send_idle_pct = 24;
    recv_stall_pct = 61;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Palette extremes: black, white, clear, primaries
    load(8'd0, 32'hFF000000);
    load(8'd1, 32'hFFFFFFFF);
    load(8'd2, 32'h00000000);
    load(8'd3, 32'hFF0000FF);
    load(8'd4, 32'hFF00FF00);
    load(8'd5, 32'hFFFF0000);
    load(8'd6, 32'h80808080);
    load(8'd7, 32'h00FFFFFF);
    set_reg(CFG_PALETTE_COUNT, 9'd8);
    dither(32'hFF808080, 8'd0, 8'd0);
    dither(32'hFF808080, 8'd1, 8'd255);
    dither(32'h00FFFFFF, 8'd2, 8'd10);
    dither(32'hFF404040, 8'd0, 8'd20);
    dither(32'h7F7F7F7F, 8'd6, 8'd5);
    set_reg(CFG_TRANSPARENT, 9'd2);
    dither(32'h00123456, 8'd1, 8'd0);
    dither(32'hFFC08040, 8'd5, 8'd30);
    set_reg(CFG_TRANSPARENT, 9'd0);
    dither(32'h00FFFFFF, 8'd7, 8'd0);
    dither(32'hFF202020, 8'd1, 8'd1);
    set_reg(CFG_MAX_MIX, 9'd255);
    dither(32'hFF7F7F7F, 8'd1, 8'd100);
    set_reg(CFG_MAX_MIX, 9'd1);
    dither(32'hFF7F7F7F, 8'd0, 8'd0);
    set_reg(CFG_MAX_MIX, 9'd0);
    dither(32'hFF7F7F7F, 8'd1, 8'd0);
    set_reg(CFG_PALETTE_COUNT, 9'd0);
    dither(32'hFF102030, 8'd3, 8'd0);
    set_reg(CFG_PALETTE_COUNT, 9'd1);
    set_reg(CFG_TRANSPARENT, NO_TRANSPARENT);
    dither(32'hFF102030, 8'd7, 8'd0);

    // Random phases, sender and receiver idling swapped for the last one
    for (int s = 8; s < 24; s++) load(8'(s), rand_color());
    random_phase(15, 31);
    random_phase(15, 31);
    send_idle_pct = 61;
    recv_stall_pct = 24;
    random_phase(15, 31);

    // No idling; long receiver hold-off while items keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= 1;
    random_phase(20, 31);

    pixel_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("two_color_mix_ordered_dither test passed");
    else
      $display("two_color_mix_ordered_dither test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tcmd_pkg.sv
sv/tcmd_ram.sv
sv/tcmd_div.sv
sv/two_color_mix_ordered_dither.sv
test/tcmd_tb_pkg.sv
test/tcmd_scoreboard.sv
test/two_color_mix_ordered_dither_tb.sv
